// ===== src/dpsd_pkg.sv =====
// Shared constants and tables of the dual-pol scattering decomposition pipeline.
package dpsd_pkg;

  localparam int unsigned SampleWidthDef = 32;

  // Fixed-point formats of the internal ratios.
  localparam int unsigned QBits     = 30;          // Q30 ratios
  localparam int unsigned RatioBits = 60;          // Q60 radicand ratio
  localparam int unsigned QuoW      = RatioBits + 1;
  localparam int unsigned DopW      = QBits + 1;   // D, 0 .. 2^30
  localparam int unsigned ProdW     = 2 * DopW;    // N and E
  localparam int unsigned SinW      = QBits + 1;   // S, 0 .. 2^30
  localparam int unsigned FactW     = QBits + 2;   // 2^30 +- S
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DopShift  = 14;
  localparam int unsigned PowShift  = 2 * QBits + 1;

  localparam int unsigned DopOutW = 17;
  localparam int unsigned ThetaW  = 24;

  localparam int unsigned CordicSteps = 28;
  localparam int unsigned CordicW     = 64;
  localparam int unsigned AngleW      = 32;

  localparam logic [FactW-1:0] One30 = FactW'(1) << QBits;
  localparam logic signed [AngleW-1:0] AngleMax = 32'sd1509949440;  // 90 degrees, Q.24

  // atan(2^-i) in degrees, Q.24
  localparam logic signed [AngleW-1:0] AtanDeg [CordicSteps] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938, 32'sd60000934,
    32'sd30029717, 32'sd15018523, 32'sd7509720, 32'sd3754917, 32'sd1877466,
    32'sd938734, 32'sd469367, 32'sd234684, 32'sd117342, 32'sd58671, 32'sd29335,
    32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833, 32'sd917, 32'sd458, 32'sd229,
    32'sd115, 32'sd57, 32'sd29, 32'sd14, 32'sd7
  };

endpackage

// ===== src/dpsd_stream_if.sv =====
// Pixel and result stream interfaces of the decomposition block.
interface dpsd_pix_if #(
  parameter int unsigned W = dpsd_pkg::SampleWidthDef
);
  logic                valid;
  logic                ready;
  logic        [W-1:0] t11_power;
  logic signed [W-1:0] offdiag_real;
  logic signed [W-1:0] offdiag_imag;
  logic        [W-1:0] t22_power;

  modport source (output valid, t11_power, offdiag_real, offdiag_imag, t22_power,
                  input ready);
  modport sink   (input valid, t11_power, offdiag_real, offdiag_imag, t22_power,
                  output ready);
endinterface

interface dpsd_res_if #(
  parameter int unsigned W = dpsd_pkg::SampleWidthDef
);
  logic                                valid;
  logic                                ready;
  logic        [dpsd_pkg::DopOutW-1:0] degree_of_pol;
  logic signed [dpsd_pkg::ThetaW-1:0]  theta_degrees;
  logic        [W-1:0]                 double_bounce_power;
  logic        [W-1:0]                 volume_power;
  logic        [W-1:0]                 surface_power;
  logic                                invalid;

  modport source (output valid, degree_of_pol, theta_degrees, double_bounce_power,
                  volume_power, surface_power, invalid, input ready);
  modport sink   (input valid, degree_of_pol, theta_degrees, double_bounce_power,
                  volume_power, surface_power, invalid, output ready);
endinterface

// ===== src/dpsd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband that travels along.
module dpsd_div #(
  parameter int unsigned NW  = 67,
  parameter int unsigned K   = 60,
  parameter int unsigned SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [NW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [K:0]     quo_o,
  output logic [SBW-1:0] sb_o
);

  logic [NW-1:0]  rem_q [K+1];
  logic [NW-1:0]  den_q [K+1];
  logic [K:0]     quo_q [K+1];
  logic [SBW-1:0] sb_q  [K+1];
  logic           vld_q [K+1];

  for (genvar i = 0; i <= K; i++) begin : g_stage
    logic [NW:0]   sh;
    logic          ge;
    logic [NW-1:0] rem_d;
    logic [K:0]    quo_d;

    if (i == 0) begin : g_first
      // The first stage takes the integer bit, which is 0 or 1 for num <= den.
      assign sh    = {1'b0, num_i};
      assign ge    = sh >= {1'b0, den_i};
      assign rem_d = ge ? NW'(sh - {1'b0, den_i}) : num_i;
      assign quo_d = {{K{1'b0}}, ge};
    end else begin : g_next
      assign sh    = {rem_q[i-1], 1'b0};
      assign ge    = sh >= {1'b0, den_q[i-1]};
      assign rem_d = ge ? NW'(sh - {1'b0, den_q[i-1]}) : NW'(sh);
      assign quo_d = {quo_q[i-1][K-1:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= (i == 0) ? valid_i : vld_q[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        quo_q[i] <= quo_d;
        den_q[i] <= (i == 0) ? den_i : den_q[(i == 0) ? 0 : i-1];
        sb_q[i]  <= (i == 0) ? sb_i : sb_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign valid_o = vld_q[K];
  assign quo_o   = quo_q[K];
  assign sb_o    = sb_q[K];

endmodule

// ===== src/dual_pol_scattering_decomposition.sv =====
// Top level of the dual-pol model-free three-component scattering decomposition.
//
// One pixel (T11, T22 and complex T12 of a 2x2 coherency matrix) enters on pix_i and one
// result leaves on res_o: degree of polarization, scattering angle, volume, surface and
// double-bounce powers and an invalid flag. Both channels use valid/ready; a transaction
// takes place when both are high.
// The block is one pipeline of 162 register stages, and a new pixel can be taken in every
// cycle in which the pipeline does not freeze (see below). The length comes from
// the long divisions (one quotient bit per stage), the integer square root (one root bit
// per stage), the 28 CORDIC steps of the angle and the wide products, which are built
// from partial products over two stages.
// When the receiver holds ready low while a result is waiting, the whole pipeline freezes
// and pix_i.ready drops; nothing is lost or repeated. While the output register is empty
// the pipeline keeps moving, so the output register fills even while ready is low.
// Reset clears all valid bits at once; the pipeline is empty and ready right after it.
// A zero trace or a zero angle denominator gives invalid = 1 and zero in all other fields.
module dual_pol_scattering_decomposition #(
  parameter int unsigned SAMPLE_WIDTH = dpsd_pkg::SampleWidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  dpsd_pix_if.sink   pix_i,
  dpsd_res_if.source res_o
);
  import dpsd_pkg::*;

  localparam int unsigned W    = SAMPLE_WIDTH;
  localparam int unsigned TW   = W + 1;
  localparam int unsigned RW   = 2 * W + 3;
  localparam int unsigned SNW  = 2 * ProdW + 1;
  localparam int unsigned PDW  = DopW + FactW;
  localparam int unsigned BPW  = PDW + TW;
  localparam int unsigned PVW  = DopW + TW;
  localparam int unsigned SB2W = TW + 3 + 2 * DopW;
  localparam int unsigned SB3W = 2 * ProdW + DopW + TW + 2;
  localparam int unsigned SB4W = SinW + DopW + TW + 2;
  localparam int unsigned HW   = ProdW / 2;
  localparam int unsigned PW2  = 2 * ProdW;
  localparam int unsigned LoW  = 32;
  localparam int unsigned LoPW = LoW + TW;
  localparam int unsigned HiPW = PDW - LoW + TW;

  logic en;
  logic res_vld_q;

  assign en          = !res_vld_q || res_o.ready;
  assign pix_i.ready = en;

  // Input stage: trace, difference and magnitudes of the cross term.
  logic [W-1:0] mr, mi;
  logic         s0_vld_q;
  logic [W-1:0] s0_a_q, s0_b_q, s0_mr_q, s0_mi_q, s0_d_q;
  logic [TW-1:0] s0_t_q;

  assign mr = pix_i.offdiag_real[W-1] ? W'(-pix_i.offdiag_real) : W'(pix_i.offdiag_real);
  assign mi = pix_i.offdiag_imag[W-1] ? W'(-pix_i.offdiag_imag) : W'(pix_i.offdiag_imag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_a_q  <= pix_i.t11_power;
      s0_b_q  <= pix_i.t22_power;
      s0_mr_q <= mr;
      s0_mi_q <= mi;
      s0_t_q  <= {1'b0, pix_i.t11_power} + {1'b0, pix_i.t22_power};
      s0_d_q  <= (pix_i.t11_power >= pix_i.t22_power) ? pix_i.t11_power - pix_i.t22_power
                                                      : pix_i.t22_power - pix_i.t11_power;
    end
  end

  // Product stage: radicand, trace squared and t11 * t22.
  logic [2*W-1:0] sq_mr, sq_mi, sq_d, prod_ab;
  logic [2*W:0]   sum_m;
  logic           s1_vld_q, s1_zt_q, s1_neg_q;
  logic [RW-1:0]  s1_r_q, s1_t2_q;
  logic [2*W-1:0] s1_ab_q;
  logic [TW-1:0]  s1_t_q;
  logic [W-1:0]   s1_d_q;

  assign sq_mr   = (2*W)'(s0_mr_q) * (2*W)'(s0_mr_q);
  assign sq_mi   = (2*W)'(s0_mi_q) * (2*W)'(s0_mi_q);
  assign sq_d    = (2*W)'(s0_d_q) * (2*W)'(s0_d_q);
  assign prod_ab = (2*W)'(s0_a_q) * (2*W)'(s0_b_q);
  assign sum_m   = {1'b0, sq_mr} + {1'b0, sq_mi};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_r_q   <= {3'b000, sq_d} + {sum_m, 2'b00};
      s1_t2_q  <= RW'(s0_t_q) * RW'(s0_t_q);
      s1_ab_q  <= prod_ab;
      s1_t_q   <= s0_t_q;
      s1_d_q   <= s0_d_q;
      s1_zt_q  <= (s0_t_q == '0);
      s1_neg_q <= (s0_a_q < s0_b_q);
    end
  end

  // Three dividers in step: R / T^2 (Q60), d / T and t11 t22 / T^2 (taken to Q30 later).
  logic           vld_a, vld_b, vld_c, zt_a, neg_b, ge_c;
  logic [QuoW-1:0] quo_a, quo_b, quo_c;
  logic [TW-1:0]  t_a;

  dpsd_div #(.NW(RW), .K(RatioBits), .SBW(TW + 1)) u_div_rad (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s1_vld_q),
    .num_i(s1_r_q), .den_i(s1_t2_q), .sb_i({s1_t_q, s1_zt_q}),
    .valid_o(vld_a), .quo_o(quo_a), .sb_o({t_a, zt_a})
  );

  dpsd_div #(.NW(TW), .K(RatioBits), .SBW(1)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s1_vld_q),
    .num_i({1'b0, s1_d_q}), .den_i(s1_t_q), .sb_i(s1_neg_q),
    .valid_o(vld_b), .quo_o(quo_b), .sb_o(neg_b)
  );

  dpsd_div #(.NW(RW), .K(RatioBits), .SBW(1)) u_div_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s1_vld_q),
    .num_i({3'b000, s1_ab_q}), .den_i(s1_t2_q), .sb_i(s1_r_q >= s1_t2_q),
    .valid_o(vld_c), .quo_o(quo_c), .sb_o(ge_c)
  );

  // Integer square root, one root bit per stage from the top down.
  logic [SB2W-1:0] sb2_in;
  logic [31:0]     sq_r_q   [SqrtSteps];
  logic [QuoW-1:0] sq_v_q   [SqrtSteps];
  logic [SB2W-1:0] sq_sb_q  [SqrtSteps];
  logic            sq_vld_q [SqrtSteps];

  assign sb2_in = {t_a, zt_a, neg_b, ge_c, quo_b[QuoW-1:QBits], quo_c[QuoW-1:QBits]};

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic [31:0]     r_in, tt;
    logic [63:0]     sq_tt;
    logic [QuoW-1:0] v_in;
    logic [SB2W-1:0] sb_in;
    logic            vld_in;

    if (k == 0) begin : g_first
      assign r_in   = '0;
      assign v_in   = quo_a;
      assign sb_in  = sb2_in;
      assign vld_in = vld_a && vld_b && vld_c;
    end else begin : g_next
      assign r_in   = sq_r_q[k-1];
      assign v_in   = sq_v_q[k-1];
      assign sb_in  = sq_sb_q[k-1];
      assign vld_in = sq_vld_q[k-1];
    end

    assign tt    = r_in | (32'd1 << (SqrtSteps - 1 - k));
    assign sq_tt = 64'(tt) * 64'(tt);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (en) begin
        sq_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_r_q[k]  <= (sq_tt <= {{(64 - QuoW){1'b0}}, v_in}) ? tt : r_in;
        sq_v_q[k]  <= v_in;
        sq_sb_q[k] <= sb_in;
      end
    end
  end

  // N = D X, D^2, then E = P 2^30 + D^2.
  logic [TW-1:0]   sb2_t;
  logic            sb2_zt, sb2_neg, sb2_ge;
  logic [DopW-1:0] sb2_x, sb2_p, dd;

  assign {sb2_t, sb2_zt, sb2_neg, sb2_ge, sb2_x, sb2_p} = sq_sb_q[SqrtSteps-1];
  assign dd = sb2_ge ? DopW'(One30) : DopW'(sq_r_q[SqrtSteps-1]);

  logic             c1_vld_q, c1_zt_q, c1_neg_q;
  logic [DopW-1:0]  c1_dd_q, c1_p_q;
  logic [ProdW-1:0] c1_num_q, c1_dd2_q;
  logic [TW-1:0]    c1_t_q;
  logic             c2_vld_q, c2_neg_q, c2_inv_q;
  logic [ProdW-1:0] c2_num_q, c2_den_q, den_c;
  logic [DopW-1:0]  c2_dd_q;
  logic [TW-1:0]    c2_t_q;

  assign den_c = ProdW'({c1_p_q, {QBits{1'b0}}}) + c1_dd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
    end else if (en) begin
      c1_vld_q <= sq_vld_q[SqrtSteps-1];
      c2_vld_q <= c1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_dd_q  <= dd;
      c1_num_q <= ProdW'(dd) * ProdW'(sb2_x);
      c1_dd2_q <= ProdW'(dd) * ProdW'(dd);
      c1_p_q   <= sb2_p;
      c1_t_q   <= sb2_t;
      c1_zt_q  <= sb2_zt;
      c1_neg_q <= sb2_neg;
      c2_num_q <= c1_num_q;
      c2_den_q <= den_c;
      c2_dd_q  <= c1_dd_q;
      c2_t_q   <= c1_t_q;
      c2_neg_q <= c1_neg_q && (c1_num_q != '0);
      c2_inv_q <= c1_zt_q || (den_c == '0);
    end
  end

  // Operands of sin(2 theta) = 2 N E / (N^2 + E^2). The wide products are built from
  // half-width partial products in one stage and summed in the next.
  logic [HW-1:0] n_hi, n_lo, e_hi, e_lo;

  assign {n_hi, n_lo} = c2_num_q;
  assign {e_hi, e_lo} = c2_den_q;

  logic               p1_vld_q, p1_neg_q, p1_inv_q;
  logic [ProdW-1:0]   p1_nd_hh_q, p1_nd_hl_q, p1_nd_lh_q, p1_nd_ll_q;
  logic [ProdW-1:0]   p1_nn_hh_q, p1_nn_hl_q, p1_nn_ll_q;
  logic [ProdW-1:0]   p1_ee_hh_q, p1_ee_hl_q, p1_ee_ll_q;
  logic [ProdW-1:0]   p1_num_q, p1_den_q;
  logic [DopW-1:0]    p1_dd_q;
  logic [TW-1:0]      p1_t_q;
  logic               d1_vld_q, d1_neg_q, d1_inv_q;
  logic [2*ProdW-1:0] d1_nd_q, d1_nn_q, d1_ee_q;
  logic [ProdW-1:0]   d1_num_q, d1_den_q;
  logic [DopW-1:0]    d1_dd_q;
  logic [TW-1:0]      d1_t_q;
  logic               d2_vld_q;
  logic [SNW-1:0]     d2_a_q, d2_s_q;
  logic [SB3W-1:0]    d2_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= c2_vld_q;
      d1_vld_q <= p1_vld_q;
      d2_vld_q <= d1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_nd_hh_q <= ProdW'(n_hi) * ProdW'(e_hi);
      p1_nd_hl_q <= ProdW'(n_hi) * ProdW'(e_lo);
      p1_nd_lh_q <= ProdW'(n_lo) * ProdW'(e_hi);
      p1_nd_ll_q <= ProdW'(n_lo) * ProdW'(e_lo);
      p1_nn_hh_q <= ProdW'(n_hi) * ProdW'(n_hi);
      p1_nn_hl_q <= ProdW'(n_hi) * ProdW'(n_lo);
      p1_nn_ll_q <= ProdW'(n_lo) * ProdW'(n_lo);
      p1_ee_hh_q <= ProdW'(e_hi) * ProdW'(e_hi);
      p1_ee_hl_q <= ProdW'(e_hi) * ProdW'(e_lo);
      p1_ee_ll_q <= ProdW'(e_lo) * ProdW'(e_lo);
      p1_num_q   <= c2_num_q;
      p1_den_q   <= c2_den_q;
      p1_dd_q    <= c2_dd_q;
      p1_t_q     <= c2_t_q;
      p1_neg_q   <= c2_neg_q;
      p1_inv_q   <= c2_inv_q;
      d1_nd_q  <= (PW2'(p1_nd_hh_q) << (2 * HW)) +
                  ((PW2'(p1_nd_hl_q) + PW2'(p1_nd_lh_q)) << HW) + PW2'(p1_nd_ll_q);
      d1_nn_q  <= (PW2'(p1_nn_hh_q) << (2 * HW)) + (PW2'(p1_nn_hl_q) << (HW + 1)) +
                  PW2'(p1_nn_ll_q);
      d1_ee_q  <= (PW2'(p1_ee_hh_q) << (2 * HW)) + (PW2'(p1_ee_hl_q) << (HW + 1)) +
                  PW2'(p1_ee_ll_q);
      d1_num_q <= p1_num_q;
      d1_den_q <= p1_den_q;
      d1_dd_q  <= p1_dd_q;
      d1_t_q   <= p1_t_q;
      d1_neg_q <= p1_neg_q;
      d1_inv_q <= p1_inv_q;
      d2_a_q   <= {d1_nd_q, 1'b0};
      d2_s_q   <= {1'b0, d1_nn_q} + {1'b0, d1_ee_q};
      d2_sb_q  <= {d1_num_q, d1_den_q, d1_dd_q, d1_t_q, d1_neg_q, d1_inv_q};
    end
  end

  logic            vld_s;
  logic [SinW-1:0] quo_s;
  logic [SB3W-1:0] sb3;

  dpsd_div #(.NW(SNW), .K(QBits), .SBW(SB3W)) u_div_sin (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d2_vld_q),
    .num_i(d2_a_q), .den_i(d2_s_q), .sb_i(d2_sb_q),
    .valid_o(vld_s), .quo_o(quo_s), .sb_o(sb3)
  );

  // CORDIC vectoring on (E / 4, N / 4), one rotation per stage.
  logic [ProdW-1:0] sb3_num, sb3_den;
  logic [DopW-1:0]  sb3_dd;
  logic [TW-1:0]    sb3_t;
  logic             sb3_neg, sb3_inv;

  assign {sb3_num, sb3_den, sb3_dd, sb3_t, sb3_neg, sb3_inv} = sb3;

  logic signed [CordicW-1:0] cx_q   [CordicSteps];
  logic signed [CordicW-1:0] cy_q   [CordicSteps];
  logic signed [AngleW-1:0]  cz_q   [CordicSteps];
  logic        [SB4W-1:0]    csb_q  [CordicSteps];
  logic                      cvld_q [CordicSteps];

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    logic signed [CordicW-1:0] x_in, y_in, xs, ys;
    logic signed [AngleW-1:0]  z_in;
    logic        [SB4W-1:0]    sb_in;
    logic                      vld_in;

    if (k == 0) begin : g_first
      assign x_in   = signed'({{(CordicW - ProdW + 2){1'b0}}, sb3_den[ProdW-1:2]});
      assign y_in   = signed'({{(CordicW - ProdW + 2){1'b0}}, sb3_num[ProdW-1:2]});
      assign z_in   = '0;
      assign sb_in  = {quo_s, sb3_dd, sb3_t, sb3_neg, sb3_inv};
      assign vld_in = vld_s;
    end else begin : g_next
      assign x_in   = cx_q[k-1];
      assign y_in   = cy_q[k-1];
      assign z_in   = cz_q[k-1];
      assign sb_in  = csb_q[k-1];
      assign vld_in = cvld_q[k-1];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cvld_q[k] <= 1'b0;
      end else if (en) begin
        cvld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!y_in[CordicW-1]) begin
          cx_q[k] <= x_in + ys;
          cy_q[k] <= y_in - xs;
          cz_q[k] <= z_in + AtanDeg[k];
        end else begin
          cx_q[k] <= x_in - ys;
          cy_q[k] <= y_in + xs;
          cz_q[k] <= z_in - AtanDeg[k];
        end
        csb_q[k] <= sb_in;
      end
    end
  end

  // Angle rounding and power factors.
  logic [SinW-1:0]          sb4_s;
  logic [DopW-1:0]          sb4_dd;
  logic [TW-1:0]            sb4_t;
  logic                     sb4_neg, sb4_inv;
  logic signed [AngleW-1:0] z_fin;
  logic [AngleW-1:0]        z_clamp, z_round;
  logic [ThetaW-1:0]        th_mag;
  logic [FactW-1:0]         f_surf, f_dbl;

  assign {sb4_s, sb4_dd, sb4_t, sb4_neg, sb4_inv} = csb_q[CordicSteps-1];
  assign z_fin   = cz_q[CordicSteps-1];
  assign z_clamp = z_fin[AngleW-1] ? '0 : (z_fin > AngleMax) ? AngleMax : z_fin;
  assign z_round = z_clamp + AngleW'(128);
  assign th_mag  = z_round[ThetaW+7:8];
  assign f_surf  = sb4_neg ? One30 - FactW'(sb4_s) : One30 + FactW'(sb4_s);
  assign f_dbl   = sb4_neg ? One30 + FactW'(sb4_s) : One30 - FactW'(sb4_s);

  logic              g1_vld_q, g1_inv_q;
  logic [PDW-1:0]    g1_ps_q, g1_pd_q;
  logic [PVW-1:0]    g1_pv_q;
  logic [TW-1:0]     g1_t_q;
  logic [DopW-1:0]   g1_dd_q;
  logic [ThetaW-1:0] g1_th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_vld_q <= 1'b0;
    end else if (en) begin
      g1_vld_q <= cvld_q[CordicSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_ps_q  <= PDW'(sb4_dd) * PDW'(f_surf);
      g1_pd_q  <= PDW'(sb4_dd) * PDW'(f_dbl);
      g1_pv_q  <= PVW'(DopW'(One30) - sb4_dd) * PVW'(sb4_t);
      g1_t_q   <= sb4_t;
      g1_dd_q  <= sb4_dd;
      g1_th_q  <= sb4_neg ? ThetaW'(~th_mag + ThetaW'(1)) : th_mag;
      g1_inv_q <= sb4_inv;
    end
  end

  // The power products times the trace are split into a low and a high partial product.
  logic              g2_vld_q, g2_inv_q;
  logic [LoPW-1:0]   g2_sl_q, g2_dl_q;
  logic [HiPW-1:0]   g2_sh_q, g2_dh_q;
  logic [PVW-1:0]    g2_pv_q;
  logic [DopW-1:0]   g2_dd_q;
  logic [ThetaW-1:0] g2_th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g2_vld_q <= 1'b0;
    end else if (en) begin
      g2_vld_q <= g1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_sl_q  <= LoPW'(g1_ps_q[LoW-1:0]) * LoPW'(g1_t_q);
      g2_sh_q  <= HiPW'(g1_ps_q[PDW-1:LoW]) * HiPW'(g1_t_q);
      g2_dl_q  <= LoPW'(g1_pd_q[LoW-1:0]) * LoPW'(g1_t_q);
      g2_dh_q  <= HiPW'(g1_pd_q[PDW-1:LoW]) * HiPW'(g1_t_q);
      g2_pv_q  <= g1_pv_q;
      g2_dd_q  <= g1_dd_q;
      g2_th_q  <= g1_th_q;
      g2_inv_q <= g1_inv_q;
    end
  end

  // Final scaling with saturation into the output register.
  logic [BPW-1:0]          bp_surf, bp_dbl;
  logic [BPW-PowShift-1:0] sh_surf, sh_dbl;
  logic [PVW-QBits-1:0]    sh_vol;
  logic [W-1:0]            sat_surf, sat_dbl, sat_vol;

  assign bp_surf  = BPW'(g2_sl_q) + (BPW'(g2_sh_q) << LoW);
  assign bp_dbl   = BPW'(g2_dl_q) + (BPW'(g2_dh_q) << LoW);
  assign sh_surf  = bp_surf[BPW-1:PowShift];
  assign sh_dbl   = bp_dbl[BPW-1:PowShift];
  assign sh_vol   = g2_pv_q[PVW-1:QBits];
  assign sat_surf = (|sh_surf[BPW-PowShift-1:W]) ? '1 : sh_surf[W-1:0];
  assign sat_dbl  = (|sh_dbl[BPW-PowShift-1:W]) ? '1 : sh_dbl[W-1:0];
  assign sat_vol  = (|sh_vol[PVW-QBits-1:W]) ? '1 : sh_vol[W-1:0];

  logic [DopOutW-1:0] dop_q;
  logic [ThetaW-1:0]  theta_q;
  logic [W-1:0]       dbl_q, vol_q, surf_q;
  logic               inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (en) begin
      res_vld_q <= g2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q   <= g2_inv_q;
      dop_q   <= g2_inv_q ? '0 : g2_dd_q[DopW-1:DopShift];
      theta_q <= g2_inv_q ? '0 : g2_th_q;
      dbl_q   <= g2_inv_q ? '0 : sat_dbl;
      vol_q   <= g2_inv_q ? '0 : sat_vol;
      surf_q  <= g2_inv_q ? '0 : sat_surf;
    end
  end

  assign res_o.valid               = res_vld_q;
  assign res_o.degree_of_pol       = dop_q;
  assign res_o.theta_degrees       = signed'(theta_q);
  assign res_o.double_bounce_power = dbl_q;
  assign res_o.volume_power        = vol_q;
  assign res_o.surface_power       = surf_q;
  assign res_o.invalid             = inv_q;

  // An invalid result carries zero in every other field.
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.invalid |-> res_o.degree_of_pol == '0 &&
      res_o.volume_power == '0 && res_o.surface_power == '0 &&
      res_o.double_bounce_power == '0 && res_o.theta_degrees == '0)
    else $error("invalid result with nonzero fields");

  // The degree of polarization never exceeds one.
  a_dop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.degree_of_pol <= DopOutW'(65536))
    else $error("degree of polarization above one");

  // Full polarization leaves no volume power.
  a_full_pol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.degree_of_pol == DopOutW'(65536) |-> res_o.volume_power == '0)
    else $error("volume power at full polarization");

endmodule
